// ===== hw/rtl/pcfc_pkg.sv =====
// Shared types, codes and reset constants of the per-class transmit credit block.
package pcfc_pkg;

  // Widths of the configuration port and of the item fields.
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_OUT_W = 24;

  // Register reset values.
  localparam int SET_LIMIT_RST  = 256;
  localparam int QBASE_RST      = 64;
  localparam int SPARE_RST      = 128;
  localparam int BE_RST         = 0;

  typedef enum logic [1:0] {
    OP_TX   = 2'd0,
    OP_RX   = 2'd1,
    OP_TICK = 2'd2
  } pcfc_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_CREDIT = 2'd1,
    ST_BLOCKED   = 2'd2
  } pcfc_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_LIMIT   = 3'd0,
    REG_QUEUE_BASE  = 3'd1,
    REG_SPARE       = 3'd2,
    REG_PORT_BLOCK  = 3'd3,
    REG_ADAPT_EN    = 3'd4,
    REG_SET_CHK_EN  = 3'd5,
    REG_BEST_EFFORT = 3'd6
  } pcfc_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic div_start;
    logic lim_load;
    logic finish;
  } pcfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic redist_req;
    logic n_zero;
    logic div_done;
  } pcfc_stat_t;

endpackage

// ===== hw/rtl/pcfc_in_if.sv =====
// Input item channel: opcode, queue index and multicast flag.
interface pcfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] priority_req;
  logic       multicast;

  modport source (output valid, output opcode, output priority_req, output multicast,
                  input ready);
  modport sink (input valid, input opcode, input priority_req, input multicast,
                output ready);
endinterface

// ===== hw/rtl/pcfc_out_if.sv =====
// Result item channel: status, timer request and credit counts.
interface pcfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        arm_timer;
  logic [23:0] queue_count;
  logic [23:0] set_count;

  modport source (output valid, output status, output arm_timer, output queue_count,
                  output set_count, input ready);
  modport sink (input valid, input status, input arm_timer, input queue_count,
                input set_count, output ready);
endinterface

// ===== hw/rtl/pcfc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface pcfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/per_class_tx_credit_flow_control.sv =====
// Top level of the per-class transmit credit flow control block.
//
//   Channel | Dir | Handshake     | Payload
//   --------+-----+---------------+---------------------------------------------
//   in_ch   | in  | valid / ready | opcode, priority_req, multicast
//   out_ch  | out | valid / ready | status, arm_timer, queue_count, set_count
//   cfg_ch  | in  | valid / ready | index (register), data
//
// An item is handled in order: it is captured, then the credit counters are
// checked and updated and the result register is loaded. A transmit or tick
// that redistributes the queue limits first runs the one bit per cycle
// divider that splits the spare credits among the in-use categories.
// Reset is synchronous and active low; all counters, limits and configuration
// registers return to their defaults at once, with no clearing pass. A stalled
// result holds the block in its update step until it is taken; the next item
// is taken while the previous result waits, and configuration writes are
// always accepted.
module per_class_tx_credit_flow_control #(
  parameter int NUM_QUEUES  = 4,
  parameter int COUNT_WIDTH = 24
) (
  input logic       clk,
  input logic       rst_n,
  pcfc_in_if.sink   in_ch,
  pcfc_out_if.source out_ch,
  pcfc_cfg_if.sink  cfg_ch
);

  pcfc_pkg::pcfc_cmd_t  cmd;
  pcfc_pkg::pcfc_stat_t stat;

  // Configuration writes never stall.
  assign cfg_ch.ready = 1'b1;

  // The controller sequences each item: capture, optional redistribution
  // through the divider, then the counter update and result hand-off.
  pcfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the registers, credit counts, limits and class masks,
  // and owns the result register that parts the two channels.
  pcfc_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_ch.opcode),
    .in_prio    (in_ch.priority_req),
    .in_mcast   (in_ch.multicast),
    .cfg_write  (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .out_status (out_ch.status),
    .out_arm    (out_ch.arm_timer),
    .out_qcount (out_ch.queue_count),
    .out_scount (out_ch.set_count)
  );

endmodule

// ===== hw/rtl/pcfc_div.sv =====
// Radix-2 restoring divider that splits the spare credits among in-use categories.
module pcfc_div #(
  parameter int DW = 24,
  parameter int NW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dvs_r, dvs_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [NW:0]   shifted;
  logic [NW:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    shifted  = {rem_r, quo_r[DW-1]};
    diff     = shifted - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits back in NW bits.
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[NW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[NW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/pcfc_ctrl.sv =====
// Controller state machine: item intake, redistribution sequencing and result hand-off.
module pcfc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pcfc_pkg::pcfc_stat_t stat,
  output pcfc_pkg::pcfc_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.redist_req && !stat.n_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.lim_load = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/pcfc_dp.sv =====
// Datapath: registers, credit counters, queue limits, class masks and result register.
module pcfc_dp #(
  parameter int NUM_QUEUES  = 4,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcfc_pkg::pcfc_cmd_t  cmd,
  output pcfc_pkg::pcfc_stat_t stat,
  input  logic [1:0]           in_opcode,
  input  logic [1:0]           in_prio,
  input  logic                 in_mcast,
  input  logic                 cfg_write,
  input  logic [pcfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcfc_pkg::CFG_W-1:0]     cfg_data,
  output logic [1:0]           out_status,
  output logic                 out_arm,
  output logic [pcfc_pkg::CNT_OUT_W-1:0] out_qcount,
  output logic [pcfc_pkg::CNT_OUT_W-1:0] out_scount
);

  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int NW  = $clog2(NUM_QUEUES + 1);
  localparam int SW  = (COUNT_WIDTH > pcfc_pkg::CFG_W) ? COUNT_WIDTH : pcfc_pkg::CFG_W;
  localparam int LW  = SW + 1;
  localparam int QCW = COUNT_WIDTH + 1;
  localparam longint CNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;
  localparam int RST_BE = pcfc_pkg::BE_RST % NUM_QUEUES;
  localparam longint LIM_BASE_RST =
    (longint'(pcfc_pkg::QBASE_RST) > CNT_MAX) ? CNT_MAX : longint'(pcfc_pkg::QBASE_RST);
  localparam longint LIM_BE_SUM = longint'(pcfc_pkg::QBASE_RST) + pcfc_pkg::SPARE_RST;
  localparam longint LIM_BE_RST = (LIM_BE_SUM > CNT_MAX) ? CNT_MAX : LIM_BE_SUM;

  localparam int CW = pcfc_pkg::CFG_W;

  // Configuration registers.
  logic [CW-1:0] set_limit_r, base_r, spare_r;
  logic          blocked_r, adapt_r, set_en_r;

  // Latched item.
  logic [1:0] op_r;
  logic [1:0] prio_r;
  logic       mcast_r;

  // Credit state.
  logic [COUNT_WIDTH-1:0] queue_used_r  [NUM_QUEUES];
  logic [COUNT_WIDTH-1:0] queue_limit_r [NUM_QUEUES];
  logic [SW-1:0]          set_used_r;
  logic [NUM_QUEUES-1:0]  in_use_r;
  logic [NUM_QUEUES-1:0]  active_r;

  // Result register.
  logic [1:0]                     status_r;
  logic                           arm_r;
  logic [pcfc_pkg::CNT_OUT_W-1:0] qcount_r, scount_r;

  // Combinational terms.
  logic                   valid;
  logic [QW-1:0]          q;
  logic [NUM_QUEUES-1:0]  bit_mask;
  logic                   tx_path, adapt_tx, tick_adapt;
  logic [NUM_QUEUES-1:0]  new_in_use, new_active;
  logic [NW-1:0]          n_cnt;
  logic [COUNT_WIDTH-1:0] q_used, q_limit, q_used_new;
  logic [SW-1:0]          set_used_new;
  logic [LW-1:0]          set_p1;
  logic [QCW-1:0]         q_p1;
  logic                   set_ok, q_ok;
  logic [1:0]             status_new;
  logic                   arm_new;
  logic [CW-1:0]          share;
  logic                   div_done;
  logic [LW-1:0]          lim_sum [NUM_QUEUES];
  logic [COUNT_WIDTH-1:0] lim_new [NUM_QUEUES];

  pcfc_div #(
    .DW (CW),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (spare_r),
    .divisor  (n_cnt),
    .done     (div_done),
    .quotient (share)
  );

  always_comb begin
    valid    = ({2'b00, prio_r} < 4'(NUM_QUEUES));
    q        = valid ? QW'(prio_r) : '0;
    bit_mask = NUM_QUEUES'(1) << q;
    q_used   = queue_used_r[q];
    q_limit  = queue_limit_r[q];

    tx_path    = (op_r == pcfc_pkg::OP_TX) && valid && !blocked_r;
    adapt_tx   = tx_path && adapt_r && !mcast_r;
    tick_adapt = (op_r == pcfc_pkg::OP_TICK) && valid && adapt_r;

    if (adapt_tx) begin
      new_in_use = in_use_r | bit_mask;
      new_active = active_r | bit_mask;
    end else if (tick_adapt) begin
      new_in_use = active_r;
      new_active = '0;
    end else begin
      new_in_use = in_use_r;
      new_active = active_r;
    end

    n_cnt = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      n_cnt = n_cnt + NW'(new_in_use[i]);
    end

    stat.redist_req = (adapt_tx && ((in_use_r & bit_mask) == '0)) ||
                      (tick_adapt && (in_use_r != active_r));
    stat.n_zero     = (n_cnt == '0);
    stat.div_done   = div_done;

    // Base, plus the share for in-use classes, saturated at the count maximum.
    for (int i = 0; i < NUM_QUEUES; i++) begin
      lim_sum[i] = LW'(base_r) + (in_use_r[i] ? LW'(share) : '0);
      lim_new[i] = (lim_sum[i] > LW'(CNT_MAX)) ? COUNT_WIDTH'(CNT_MAX)
                                               : COUNT_WIDTH'(lim_sum[i]);
    end

    // The set count is incremented only when both the set and the queue check
    // pass, so a failed queue check leaves it unchanged.
    set_p1 = LW'(set_used_r) + LW'(1);
    q_p1   = QCW'(q_used) + QCW'(1);
    set_ok = !set_en_r || (set_p1 < LW'(set_limit_r));
    q_ok   = q_p1 < QCW'(q_limit);

    status_new   = pcfc_pkg::ST_OK;
    arm_new      = adapt_tx && (active_r == '0);
    q_used_new   = q_used;
    set_used_new = set_used_r;
    case (op_r)
      pcfc_pkg::OP_TX: begin
        if (!valid) begin
          status_new = pcfc_pkg::ST_NO_CREDIT;
        end else if (blocked_r) begin
          status_new = pcfc_pkg::ST_BLOCKED;
        end else if (set_ok && q_ok) begin
          q_used_new = q_used + COUNT_WIDTH'(1);
          if (set_en_r) begin
            set_used_new = set_used_r + SW'(1);
          end
        end else begin
          status_new = pcfc_pkg::ST_NO_CREDIT;
        end
      end
      pcfc_pkg::OP_RX: begin
        if (!valid) begin
          status_new = pcfc_pkg::ST_NO_CREDIT;
        end else begin
          if (set_en_r && (set_used_r != '0)) begin
            set_used_new = set_used_r - SW'(1);
          end
          if (q_used != '0) begin
            q_used_new = q_used - COUNT_WIDTH'(1);
          end
        end
      end
      default: begin
        if (!valid) begin
          status_new = pcfc_pkg::ST_NO_CREDIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_limit_r <= CW'(pcfc_pkg::SET_LIMIT_RST);
      base_r      <= CW'(pcfc_pkg::QBASE_RST);
      spare_r     <= CW'(pcfc_pkg::SPARE_RST);
      blocked_r   <= 1'b1;
      adapt_r     <= 1'b1;
      set_en_r    <= 1'b1;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_used_r[i]  <= '0;
        queue_limit_r[i] <= (i == RST_BE) ? COUNT_WIDTH'(LIM_BE_RST)
                                          : COUNT_WIDTH'(LIM_BASE_RST);
      end
      set_used_r <= '0;
      in_use_r   <= NUM_QUEUES'(1) << RST_BE;
      active_r   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          pcfc_pkg::REG_SET_LIMIT:   set_limit_r <= cfg_data;
          pcfc_pkg::REG_QUEUE_BASE:  base_r      <= cfg_data;
          pcfc_pkg::REG_SPARE:       spare_r     <= cfg_data;
          pcfc_pkg::REG_PORT_BLOCK:  blocked_r   <= cfg_data[0];
          pcfc_pkg::REG_ADAPT_EN:    adapt_r     <= cfg_data[0];
          pcfc_pkg::REG_SET_CHK_EN:  set_en_r    <= cfg_data[0];
          // The best-effort index only shapes the reset state, and reset
          // always restores its default, so a write has nothing to steer.
          pcfc_pkg::REG_BEST_EFFORT: ;
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        in_use_r <= new_in_use;
      end
      if (cmd.lim_load) begin
        for (int i = 0; i < NUM_QUEUES; i++) begin
          queue_limit_r[i] <= lim_new[i];
        end
      end
      if (cmd.finish) begin
        in_use_r   <= new_in_use;
        active_r   <= new_active;
        set_used_r <= set_used_new;
        if (valid) begin
          queue_used_r[q] <= q_used_new;
        end
      end
    end
    if (cmd.load_item) begin
      op_r    <= in_opcode;
      prio_r  <= in_prio;
      mcast_r <= in_mcast;
    end
    if (cmd.finish) begin
      status_r <= status_new;
      arm_r    <= arm_new;
      qcount_r <= valid ? pcfc_pkg::CNT_OUT_W'(q_used_new) : '0;
      scount_r <= pcfc_pkg::CNT_OUT_W'(set_used_new[COUNT_WIDTH-1:0]);
    end
  end

  assign out_status = status_r;
  assign out_arm    = arm_r;
  assign out_qcount = qcount_r;
  assign out_scount = scount_r;

endmodule

// ===== test/per_class_tx_credit_flow_control_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts every result of the per-class credit block and compares it.
module per_class_tx_credit_flow_control_checker (
  input  logic clk,
  input  logic rst_n,
  pcfc_in_if   in_ch,
  pcfc_out_if  out_ch,
  pcfc_cfg_if  cfg_ch,
  output int   failures,
  output int   pending
);

  localparam int          NQ      = 4;
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  typedef struct packed {
    pcfc_pkg::pcfc_status_t status;
    logic                   arm_timer;
    logic [23:0]            queue_count;
    logic [23:0]            set_count;
  } credit_result_t;

  credit_result_t expected_results[$];
  credit_result_t oldest;

  // Register copies.
  logic [23:0] set_limit;
  logic [23:0] queue_base;
  logic [23:0] spare;
  logic        port_blocked;
  logic        adapt_en;
  logic        set_chk_en;
  logic [1:0]  best_effort;

  // Credit state.
  logic [23:0]   queue_used [NQ];
  logic [23:0]   queue_limit[NQ];
  logic [23:0]   set_used;
  logic [NQ-1:0] classes_in_use;
  logic [NQ-1:0] classes_active;

  // Every queue gets the base limit; in-use classes also get an equal part of
  // the spare credits. With no class in use the limits stay as they are.
  function automatic void share_spare_credits();
    int          n;
    logic [23:0] share;
    logic [24:0] lim;
    n = $countones(classes_in_use);
    if (n == 0) return;
    share = spare / n;
    for (int i = 0; i < NQ; i++) begin
      lim = {1'b0, queue_base} + (classes_in_use[i] ? {1'b0, share} : 25'd0);
      queue_limit[i] = lim[24] ? CNT_MAX : lim[23:0];
    end
  endfunction

  function automatic void reset_credit_state();
    logic [24:0] lim;
    set_limit    = 24'(pcfc_pkg::SET_LIMIT_RST);
    queue_base   = 24'(pcfc_pkg::QBASE_RST);
    spare        = 24'(pcfc_pkg::SPARE_RST);
    port_blocked = 1'b1;
    adapt_en     = 1'b1;
    set_chk_en   = 1'b1;
    best_effort  = 2'(pcfc_pkg::BE_RST);
    for (int i = 0; i < NQ; i++) begin
      lim = {1'b0, queue_base} + ((i == best_effort) ? {1'b0, spare} : 25'd0);
      queue_used[i]  = '0;
      queue_limit[i] = lim[24] ? CNT_MAX : lim[23:0];
    end
    set_used       = '0;
    classes_in_use = NQ'(1) << best_effort;
    classes_active = '0;
  endfunction

  function automatic credit_result_t credit_step(logic [1:0] op, logic [1:0] q, logic mc);
    credit_result_t r;
    logic           set_ok;
    r.status    = pcfc_pkg::ST_OK;
    r.arm_timer = 1'b0;
    set_ok      = 1'b1;
    case (op)
      pcfc_pkg::OP_TX: begin
        if (port_blocked) begin
          r.status = pcfc_pkg::ST_BLOCKED;
        end else begin
          if (adapt_en && !mc) begin
            if (!classes_in_use[q]) begin
              classes_in_use[q] = 1'b1;
              share_spare_credits();
            end
            // The timer request stands even if the credit check drops the item.
            if (classes_active == '0) r.arm_timer = 1'b1;
            classes_active[q] = 1'b1;
          end
          if (set_chk_en) begin
            if (set_used + 25'd1 >= set_limit) begin
              r.status = pcfc_pkg::ST_NO_CREDIT;
              set_ok   = 1'b0;
            end else begin
              set_used = set_used + 24'd1;
            end
          end
          if (set_ok) begin
            if (queue_used[q] + 25'd1 >= queue_limit[q]) begin
              r.status = pcfc_pkg::ST_NO_CREDIT;
              if (set_chk_en && set_used != '0) set_used = set_used - 24'd1;
            end else begin
              queue_used[q] = queue_used[q] + 24'd1;
            end
          end
        end
      end
      pcfc_pkg::OP_RX: begin
        if (set_chk_en && set_used != '0) set_used = set_used - 24'd1;
        if (queue_used[q] != '0) queue_used[q] = queue_used[q] - 24'd1;
      end
      pcfc_pkg::OP_TICK: begin
        if (adapt_en) begin
          if (classes_in_use != classes_active) begin
            classes_in_use = classes_active;
            share_spare_credits();
          end
          classes_active = '0;
        end
      end
      default: begin
      end
    endcase
    r.queue_count = queue_used[q];
    r.set_count   = set_used;
    return r;
  endfunction

  function automatic void check_field(string field, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_credit_state();
      expected_results.delete();
      failures = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          pcfc_pkg::REG_SET_LIMIT:   set_limit    = cfg_ch.data;
          pcfc_pkg::REG_QUEUE_BASE:  queue_base   = cfg_ch.data;
          pcfc_pkg::REG_SPARE:       spare        = cfg_ch.data;
          pcfc_pkg::REG_PORT_BLOCK:  port_blocked = cfg_ch.data[0];
          pcfc_pkg::REG_ADAPT_EN:    adapt_en     = cfg_ch.data[0];
          pcfc_pkg::REG_SET_CHK_EN:  set_chk_en   = cfg_ch.data[0];
          pcfc_pkg::REG_BEST_EFFORT: best_effort  = cfg_ch.data[1:0];
          default: begin
          end
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          failures++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", 24'(oldest.status), 24'(out_ch.status));
          check_field("arm_timer", 24'(oldest.arm_timer), 24'(out_ch.arm_timer));
          check_field("queue_count", oldest.queue_count, out_ch.queue_count);
          check_field("set_count", oldest.set_count, out_ch.set_count);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(credit_step(in_ch.opcode, in_ch.priority_req,
                                               in_ch.multicast));
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/per_class_tx_credit_flow_control_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: stimulus, handshake pacing, watchdog and verdict for the credit block.
module per_class_tx_credit_flow_control_tb;

  // Opcode 3 has no name in the package; the block must answer it without any change.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Register index 7 addresses nothing; a write there must be ignored.
  localparam logic [2:0] REG_NONE = 3'd7;

  // A long hold-off of the result side, used once to make the block stall its input.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any accepted item before the run is declared hung. The worst
  // legal quiet stretch is the hold-off plus one redistributing item.
  localparam int IDLE_LIMIT = 5000;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 86;

  logic clk = 1'b0;
  logic rst_n;

  pcfc_in_if  in_ch();
  pcfc_out_if out_ch();
  pcfc_cfg_if cfg_ch();

  int failures;
  int pending;

  // Pacing controls shared between the stimulus and the result side.
  bit in_no_gaps  = 1'b0;
  bit out_no_gaps = 1'b0;
  bit hold_req    = 1'b0;

  int op_count[4];
  int settings_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  per_class_tx_credit_flow_control u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  per_class_tx_credit_flow_control_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .failures (failures),
    .pending  (pending)
  );

  // Gap lengths: mostly none or short ones, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item and returns right after the edge at which it is accepted.
  // Valid stays high on return, so back-to-back items never drop it in between.
  task automatic send_item(input logic [1:0] op, input logic [1:0] q, input logic mc);
    int gap;
    gap = in_no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.priority_req <= q;
    in_ch.multicast    <= mc;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    op_count[op]++;
  endtask

  // Stops offering items and waits until every expected result has been taken,
  // which leaves the block idle and safe for register writes.
  task automatic finish_items();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Limits are mostly small so that the set and queue checks trip often; the
  // extremes of the 24-bit range show up now and then.
  function automatic logic [23:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd1;
    if (r < 30) return 24'($urandom_range(17, 300));
    return 24'($urandom_range(1, 16));
  endfunction

  // One-bit and two-bit registers get random upper data bits, which the block
  // must ignore.
  function automatic logic [23:0] flag_data(input logic [1:0] low_bits);
    logic [23:0] d;
    d      = 24'($urandom);
    d[1:0] = low_bits;
    return d;
  endfunction

  task automatic random_settings();
    logic [23:0] spare_val;
    if ($urandom_range(0, 9) < 6) write_reg(pcfc_pkg::REG_SET_LIMIT, pick_limit());
    if ($urandom_range(0, 9) < 6) write_reg(pcfc_pkg::REG_QUEUE_BASE, pick_limit());
    if ($urandom_range(0, 9) < 6) begin
      if ($urandom_range(0, 9) == 0)
        spare_val = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd0;
      else
        spare_val = 24'($urandom_range(0, 40));
      write_reg(pcfc_pkg::REG_SPARE, spare_val);
    end
    // The port is unblocked in most settings so transmits reach the credit checks.
    write_reg(pcfc_pkg::REG_PORT_BLOCK, flag_data({1'b0, $urandom_range(0, 99) < 15}));
    if ($urandom_range(0, 9) < 6)
      write_reg(pcfc_pkg::REG_ADAPT_EN, flag_data({1'b0, $urandom_range(0, 99) < 75}));
    if ($urandom_range(0, 9) < 6)
      write_reg(pcfc_pkg::REG_SET_CHK_EN, flag_data({1'b0, $urandom_range(0, 99) < 75}));
    if ($urandom_range(0, 9) < 3)
      write_reg(pcfc_pkg::REG_BEST_EFFORT, flag_data(2'($urandom_range(0, 3))));
    settings_count++;
  endtask

  // Random traffic that leans on one queue per phase, so its count climbs into
  // its limit while the other classes still come and go.
  task automatic random_phase(input int n_items);
    int         r;
    logic [1:0] hot;
    logic [1:0] op;
    logic [1:0] q;
    hot = 2'($urandom_range(0, 3));
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50)      op = pcfc_pkg::OP_TX;
      else if (r < 78) op = pcfc_pkg::OP_RX;
      else if (r < 92) op = pcfc_pkg::OP_TICK;
      else             op = OP_UNUSED;
      q = ($urandom_range(0, 99) < 60) ? hot : 2'($urandom_range(0, 3));
      send_item(op, q, $urandom_range(0, 3) == 0);
    end
  endtask

  // Hand-picked sequence: blocked port, floors at zero, ticks with no class in
  // use, redistribution as classes join, set and queue refusals, a rollback of
  // the set count, saturated limits, and the disabled checks.
  task automatic directed_items();
    // Reset state keeps the port blocked.
    send_item(pcfc_pkg::OP_TX, 2'd0, 1'b0);
    send_item(pcfc_pkg::OP_RX, 2'd1, 1'b0);
    send_item(pcfc_pkg::OP_TICK, 2'd0, 1'b0);
    send_item(OP_UNUSED, 2'd3, 1'b1);
    finish_items();

    write_reg(pcfc_pkg::REG_PORT_BLOCK, 24'd0);
    write_reg(pcfc_pkg::REG_SET_LIMIT, 24'd6);
    write_reg(pcfc_pkg::REG_QUEUE_BASE, 24'd2);
    write_reg(pcfc_pkg::REG_SPARE, 24'd3);
    write_reg(pcfc_pkg::REG_SET_CHK_EN, 24'd1);
    write_reg(pcfc_pkg::REG_ADAPT_EN, 24'd1);
    write_reg(pcfc_pkg::REG_BEST_EFFORT, 24'd3);
    write_reg(REG_NONE, 24'hFFFFFF);
    settings_count++;
    send_item(pcfc_pkg::OP_TX, 2'd0, 1'b0);
    send_item(pcfc_pkg::OP_TX, 2'd0, 1'b1);
    // Queue 1 joins and shrinks the share of queue 0 below its count.
    send_item(pcfc_pkg::OP_TX, 2'd1, 1'b0);
    send_item(pcfc_pkg::OP_TX, 2'd0, 1'b0);
    send_item(pcfc_pkg::OP_TX, 2'd2, 1'b1);
    send_item(pcfc_pkg::OP_TX, 2'd3, 1'b0);
    // This one hits the set limit.
    send_item(pcfc_pkg::OP_TX, 2'd1, 1'b0);
    send_item(pcfc_pkg::OP_RX, 2'd0, 1'b0);
    send_item(pcfc_pkg::OP_TICK, 2'd2, 1'b0);
    send_item(pcfc_pkg::OP_TICK, 2'd1, 1'b0);
    send_item(pcfc_pkg::OP_TX, 2'd2, 1'b0);
    finish_items();

    // Base plus share overflows the counter width and must saturate.
    write_reg(pcfc_pkg::REG_QUEUE_BASE, 24'hFFFFFF);
    write_reg(pcfc_pkg::REG_SPARE, 24'hFFFFFF);
    write_reg(pcfc_pkg::REG_SET_CHK_EN, 24'd0);
    settings_count++;
    send_item(pcfc_pkg::OP_TX, 2'd1, 1'b0);
    send_item(pcfc_pkg::OP_TX, 2'd0, 1'b0);
    send_item(pcfc_pkg::OP_RX, 2'd1, 1'b0);
    finish_items();

    write_reg(pcfc_pkg::REG_SET_LIMIT, 24'd1);
    write_reg(pcfc_pkg::REG_ADAPT_EN, 24'd0);
    write_reg(pcfc_pkg::REG_SET_CHK_EN, 24'd1);
    settings_count++;
    send_item(pcfc_pkg::OP_TX, 2'd3, 1'b0);
    send_item(pcfc_pkg::OP_TICK, 2'd0, 1'b0);
    finish_items();

    write_reg(pcfc_pkg::REG_SET_LIMIT, 24'hFFFFFF);
    write_reg(pcfc_pkg::REG_QUEUE_BASE, 24'd1);
    write_reg(pcfc_pkg::REG_SPARE, 24'd0);
    write_reg(pcfc_pkg::REG_ADAPT_EN, 24'd1);
    settings_count++;
    send_item(pcfc_pkg::OP_TX, 2'd2, 1'b0);
    send_item(pcfc_pkg::OP_TX, 2'd2, 1'b1);
    send_item(pcfc_pkg::OP_RX, 2'd3, 1'b0);
    finish_items();
  endtask

  // Result side: random stalls, optional full speed, and one long hold-off that
  // is counted here so the sender keeps pushing while the block backs up.
  initial begin
    int stall_left;
    int g;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (out_no_gaps) begin
        out_ch.ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = g - 1;
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("per_class_tx_credit_flow_control test failed");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.opcode       = 2'd0;
    in_ch.priority_req = 2'd0;
    in_ch.multicast    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = 3'd0;
    cfg_ch.data        = 24'd0;
    rst_n              = 1'b0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_items();

    // Each phase starts from a fresh random setting. Counts carry over, so a
    // lowered limit often lands below the count already in use. Phase 3 holds
    // the result side off with the sender at full rate; phase 6 runs both
    // sides without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      random_settings();
      in_no_gaps  = (p == 3) || (p == 6);
      out_no_gaps = (p == 6);
      if (p == 3) hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
      finish_items();
    end

    // Let any late result show up as an unexpected item.
    repeat (40) @(posedge clk);

    $display("Covered %0d items: %0d transmit, %0d receive, %0d tick, %0d unused opcode,",
             op_count[pcfc_pkg::OP_TX] + op_count[pcfc_pkg::OP_RX] +
             op_count[pcfc_pkg::OP_TICK] + op_count[OP_UNUSED],
             op_count[pcfc_pkg::OP_TX], op_count[pcfc_pkg::OP_RX],
             op_count[pcfc_pkg::OP_TICK], op_count[OP_UNUSED]);
    $display("under %0d register settings, with one long result hold-off; %0d mismatches.",
             settings_count, failures);
    if (failures == 0)
      $display("per_class_tx_credit_flow_control test passed");
    else
      $display("per_class_tx_credit_flow_control test failed");
    $finish;
  end

endmodule
